// ===== rtl/core/dq_pkg.sv =====
// shared types and codes for the double-ended queue
`timescale 1ns / 1ps

package dq_pkg;

  // command codes carried on the input transfer
  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_e;

  // error codes carried on the result transfer
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  // operation broadcast to every storage cell
  typedef enum logic [2:0] {
    OP_HOLD        = 3'd0,
    OP_SHIFT_RIGHT = 3'd1,
    OP_SHIFT_LEFT  = 3'd2,
    OP_PUSH_TAIL   = 3'd3,
    OP_POP_TAIL    = 3'd4
  } cell_op_e;

endpackage

// ===== rtl/core/double_ended_queue.sv =====
// double-ended queue top level: command decode, cell chain and result port
// result: offered in the cycle after its command transfer
// throughput: one command per cycle while results are taken; each command
//   moves the whole cell chain by at most one place
// reset: all cells empty, count zero, no result pending; words need no reset
`timescale 1ns / 1ps

module double_ended_queue import dq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CntW      = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            command_i,
  input  logic [DATA_WIDTH-1:0] data_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] front_value_o,
  output logic [DATA_WIDTH-1:0] back_value_o,
  output logic [CntW-1:0]       occupancy_o,
  output logic                  is_empty_o,
  output logic [1:0]            error_code_o
);

  logic                  out_valid_q, out_valid_d;
  err_e                  err_q, err_d;
  logic [CntW-1:0]       count_q, count_d;
  cell_op_e              cell_op;
  logic                  in_xfer;
  logic                  is_full;
  logic                  is_zero;
  logic [DEPTH-1:0]      cell_valid;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tail [DEPTH];
  logic [DATA_WIDTH-1:0] back_word;

  // a new command may enter once the pending result leaves
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CntW'(DEPTH));
  assign is_zero    = (count_q == '0);

  // command decode into cell op, count update and error
  always_comb begin
    cell_op = OP_HOLD;
    count_d = count_q;
    err_d   = err_q;
    if (in_xfer) begin
      err_d = ERR_NONE;
      case (cmd_e'(command_i))
        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
          if (is_full) begin
            err_d = ERR_FULL;
          end else begin
            cell_op = (cmd_e'(command_i) == CMD_PUSH_BACK) ? OP_PUSH_TAIL : OP_SHIFT_RIGHT;
            count_d = count_q + CntW'(1);
          end
        end
        CMD_POP_BACK, CMD_POP_FRONT: begin
          if (is_zero) begin
            err_d = ERR_EMPTY;
          end else begin
            cell_op = (cmd_e'(command_i) == CMD_POP_BACK) ? OP_POP_TAIL : OP_SHIFT_LEFT;
            count_d = count_q - CntW'(1);
          end
        end
        default: begin
          cell_op = OP_HOLD;
        end
      endcase
    end
  end

  // result handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
      err_q       <= ERR_NONE;
    end else begin
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      err_q       <= err_d;
    end
  end

  // chain of cells, front at cell zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  left_valid, right_valid;
    logic [DATA_WIDTH-1:0] left_data, right_data;

    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
      assign left_data  = data_in_i;
    end else begin : g_mid
      assign left_valid = cell_valid[i-1];
      assign left_data  = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_valid = 1'b0;
      assign right_data  = '0;
    end else begin : g_inner
      assign right_valid = cell_valid[i+1];
      assign right_data  = cell_data[i+1];
    end

    dq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (cell_op),
      .push_data_i   (data_in_i),
      .left_valid_i  (left_valid),
      .left_data_i   (left_data),
      .right_valid_i (right_valid),
      .right_data_i  (right_data),
      .valid_o       (cell_valid[i]),
      .data_o        (cell_data[i]),
      .tail_data_o   (cell_tail[i])
    );
  end

  // only the last occupied cell drives a nonzero tail word
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | cell_tail[i];
    end
  end

  // result fields
  assign front_value_o = cell_valid[0] ? cell_data[0] : '0;
  assign back_value_o  = back_word;
  assign occupancy_o   = count_q;
  assign is_empty_o    = is_zero;
  assign error_code_o  = err_q;
  assign out_valid_o   = out_valid_q;

endmodule

// ===== rtl/core/dq_cell.sv =====
// one storage cell of the queue chain: a word and its valid bit
`timescale 1ns / 1ps

module dq_cell import dq_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_op_e              op_i,
  input  logic [DATA_WIDTH-1:0] push_data_i,
  input  logic                  left_valid_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic                  right_valid_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  output logic                  valid_o,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] tail_data_o
);

  logic                  valid_q, valid_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  data_we;

  // local next state from the broadcast op and the two neighbors
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    data_we = 1'b0;
    case (op_i)
      OP_SHIFT_RIGHT: begin
        valid_d = left_valid_i;
        data_d  = left_data_i;
        data_we = 1'b1;
      end
      OP_SHIFT_LEFT: begin
        valid_d = right_valid_i;
        data_d  = right_data_i;
        data_we = 1'b1;
      end
      OP_PUSH_TAIL: begin
        // first empty cell behind the occupied run takes the word
        if (left_valid_i && !valid_q) begin
          valid_d = 1'b1;
          data_d  = push_data_i;
          data_we = 1'b1;
        end
      end
      OP_POP_TAIL: begin
        // last occupied cell lets go
        if (valid_q && !right_valid_i) begin
          valid_d = 1'b0;
        end
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // word storage
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_q <= data_d;
    end
  end

  assign valid_o     = valid_q;
  assign data_o      = data_q;
  assign tail_data_o = (valid_q && !right_valid_i) ? data_q : '0;

endmodule

// ===== rtl/core/dq_checker.sv =====
// port-level checks for the double-ended queue, bound to the top level
`timescale 1ns / 1ps

module dq_checker import dq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CntW      = $clog2(DEPTH + 1)
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [2:0]            command_i,
  input logic [DATA_WIDTH-1:0] data_in_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [DATA_WIDTH-1:0] front_value_o,
  input logic [DATA_WIDTH-1:0] back_value_o,
  input logic [CntW-1:0]       occupancy_o,
  input logic                  is_empty_o,
  input logic [1:0]            error_code_o
);

  // occupancy stays within the capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (occupancy_o <= CntW'(DEPTH)))
    else $error("occupancy above capacity");

  // empty flag agrees with occupancy
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (occupancy_o == '0)))
    else $error("empty flag disagrees with occupancy");

  // empty queue shows zero words
  a_empty_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (front_value_o == '0 && back_value_o == '0))
    else $error("nonzero word on empty queue");

  // an accepted push raises occupancy by one unless it reports full
  a_push_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && out_valid_o && out_ready_i &&
     (command_i == CMD_PUSH_BACK || command_i == CMD_PUSH_FRONT))
    |=> (occupancy_o == $past(occupancy_o) + CntW'(1)) ||
        (error_code_o == ERR_FULL))
    else $error("push did not grow occupancy by one");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(front_value_o) &&
     $stable(back_value_o) && $stable(occupancy_o) && $stable(error_code_o)))
    else $error("stalled result changed");

endmodule

bind double_ended_queue dq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_dq_checker (.*);
